// ===== rtl/lr_pkg.sv =====
// ----------------------------------------------------------------------------
// Line rasterizer package
// Shared types, widths and codes for the midpoint line rasterizer.
// ----------------------------------------------------------------------------
`default_nettype none

package lr_pkg;

  localparam int COORD_BITS = 16;
  localparam int DEC_BITS   = COORD_BITS + 3;
  localparam int FIELD_BITS = 16;
  localparam int WORD_BITS  = 32;

  localparam logic [15:0] LINE_WIDTH_RESET = 16'd1024;

  localparam logic CMD_BEGIN = 1'b0;
  localparam logic CMD_STEP  = 1'b1;

  localparam logic REG_BASE_ADDRESS = 1'b0;
  localparam logic REG_LINE_WIDTH   = 1'b1;

  typedef struct packed {
    logic                  cmd;
    logic [FIELD_BITS-1:0] start_x;
    logic [FIELD_BITS-1:0] start_y;
    logic [FIELD_BITS-1:0] end_x;
    logic [FIELD_BITS-1:0] end_y;
    logic [WORD_BITS-1:0]  line_color;
  } lr_in_t;

  typedef struct packed {
    logic [FIELD_BITS-1:0] pix_x;
    logic [FIELD_BITS-1:0] pix_y;
    logic [WORD_BITS-1:0]  pixel_index;
    logic [WORD_BITS-1:0]  pixel_color;
    logic                  last_pixel;
  } lr_out_t;

endpackage

`default_nettype wire

// ===== rtl/line_rasterizer_top.sv =====
// ----------------------------------------------------------------------------
// Line rasterizer top level
// Midpoint line stepper with framebuffer word index generation.
// ----------------------------------------------------------------------------
// Throughput: one transaction per cycle while out_ready_i does not stall;
// the stepper state updates in the accept cycle (one add and compare), the
// index multiply-add has a stage of its own. Reset: idle, base address 0,
// line width 1024, no results pending.
`default_nettype none

module line_rasterizer_top (
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire logic                cfg_we_i,
  input  wire logic                cfg_addr_i,
  input  wire logic [31:0]         cfg_wdata_i,
  input  wire logic                in_valid_i,
  output      logic                in_ready_o,
  input  wire lr_pkg::lr_in_t      in_data_i,
  output      logic                out_valid_o,
  input  wire logic                out_ready_i,
  output      lr_pkg::lr_out_t     out_data_o
);

  localparam int CB = lr_pkg::COORD_BITS;
  localparam int DB = lr_pkg::DEC_BITS;

  logic [31:0] base_address_q;
  logic [15:0] line_width_q;

  logic [CB-1:0]        cur_x_q, cur_x_d, cur_y_q, cur_y_d;
  logic [CB-1:0]        stop_x_q, stop_x_d, stop_y_q, stop_y_d;
  logic signed [DB-1:0] decision_q, decision_d;
  logic signed [DB-1:0] straight_q, straight_d, diagonal_q, diagonal_d;
  logic                 x_major_q, x_major_d;
  logic                 neg_x_q, neg_x_d, neg_y_q, neg_y_d;
  logic [31:0]          color_q, color_d;
  logic                 busy_q, busy_d;
  logic                 emit_d, last_d;

  logic          s1_valid_q;
  logic [CB-1:0] s1_x_q, s1_y_q;
  logic [31:0]   s1_color_q;
  logic          s1_last_q;

  logic            out_valid_q;
  lr_pkg::lr_out_t out_q;

  logic in_fire, out_load;

  assign out_load   = !out_valid_q || out_ready_i;
  assign in_ready_o = !s1_valid_q || out_load;
  assign in_fire    = in_valid_i && in_ready_o;

  // Configuration
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      base_address_q <= '0;
      line_width_q   <= lr_pkg::LINE_WIDTH_RESET;
    end else if (cfg_we_i) begin
      case (cfg_addr_i)
        lr_pkg::REG_BASE_ADDRESS: base_address_q <= cfg_wdata_i;
        lr_pkg::REG_LINE_WIDTH:   line_width_q   <= cfg_wdata_i[15:0];
        default:                  base_address_q <= base_address_q;
      endcase
    end
  end

  // Stepper
  logic [CB-1:0]        x0, y0, x1, y1, ax, ay, major, minor;
  logic                 xm;
  logic signed [DB-1:0] maj_s, min_s, diff_s;
  logic [CB-1:0]        nx, ny;
  logic                 dec_le0;

  always_comb begin
    x0     = in_data_i.start_x[CB-1:0];
    y0     = in_data_i.start_y[CB-1:0];
    x1     = in_data_i.end_x[CB-1:0];
    y1     = in_data_i.end_y[CB-1:0];
    ax     = (x1 > x0) ? (x1 - x0) : (x0 - x1);
    ay     = (y1 > y0) ? (y1 - y0) : (y0 - y1);
    xm     = ax > ay;
    major  = xm ? ax : ay;
    minor  = xm ? ay : ax;
    maj_s  = DB'(major);
    min_s  = DB'(minor);
    diff_s = min_s - maj_s;

    dec_le0 = decision_q[DB-1] || (decision_q == '0);
    nx = neg_x_q ? (cur_x_q - CB'(1)) : (cur_x_q + CB'(1));
    ny = neg_y_q ? (cur_y_q - CB'(1)) : (cur_y_q + CB'(1));

    cur_x_d    = cur_x_q;
    cur_y_d    = cur_y_q;
    stop_x_d   = stop_x_q;
    stop_y_d   = stop_y_q;
    decision_d = decision_q;
    straight_d = straight_q;
    diagonal_d = diagonal_q;
    x_major_d  = x_major_q;
    neg_x_d    = neg_x_q;
    neg_y_d    = neg_y_q;
    color_d    = color_q;
    busy_d     = busy_q;
    emit_d     = 1'b0;
    last_d     = 1'b0;

    if (in_data_i.cmd == lr_pkg::CMD_BEGIN) begin
      cur_x_d    = x0;
      cur_y_d    = y0;
      stop_x_d   = x1;
      stop_y_d   = y1;
      color_d    = in_data_i.line_color;
      neg_x_d    = !(x1 > x0);
      neg_y_d    = !(y1 > y0);
      x_major_d  = xm;
      straight_d = min_s + min_s;
      diagonal_d = diff_s + diff_s;
      decision_d = min_s + min_s - maj_s;
      last_d     = xm ? (x0 == x1) : (y0 == y1);
      busy_d     = !last_d;
      emit_d     = 1'b1;
    end else if (busy_q) begin
      if (dec_le0) begin
        decision_d = decision_q + straight_q;
        if (x_major_q) begin
          cur_x_d = nx;
        end else begin
          cur_y_d = ny;
        end
      end else begin
        decision_d = decision_q + diagonal_q;
        cur_x_d    = nx;
        cur_y_d    = ny;
      end
      last_d = x_major_q ? (cur_x_d == stop_x_q) : (cur_y_d == stop_y_q);
      busy_d = !last_d;
      emit_d = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cur_x_q    <= '0;
      cur_y_q    <= '0;
      stop_x_q   <= '0;
      stop_y_q   <= '0;
      decision_q <= '0;
      straight_q <= '0;
      diagonal_q <= '0;
      x_major_q  <= 1'b0;
      neg_x_q    <= 1'b0;
      neg_y_q    <= 1'b0;
      color_q    <= '0;
      busy_q     <= 1'b0;
    end else if (in_fire) begin
      cur_x_q    <= cur_x_d;
      cur_y_q    <= cur_y_d;
      stop_x_q   <= stop_x_d;
      stop_y_q   <= stop_y_d;
      decision_q <= decision_d;
      straight_q <= straight_d;
      diagonal_q <= diagonal_d;
      x_major_q  <= x_major_d;
      neg_x_q    <= neg_x_d;
      neg_y_q    <= neg_y_d;
      color_q    <= color_d;
      busy_q     <= busy_d;
    end
  end

  // Pixel stage
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else if (in_fire) begin
      s1_valid_q <= emit_d;
    end else if (out_load) begin
      s1_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      s1_x_q     <= cur_x_d;
      s1_y_q     <= cur_y_d;
      s1_color_q <= color_d;
      s1_last_q  <= last_d;
    end
  end

  // Index stage
  logic [31:0] row_off, index_d;

  assign row_off = 32'(line_width_q) * 32'(s1_y_q);
  assign index_d = base_address_q + row_off + 32'(s1_x_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (out_load) begin
      out_valid_q <= s1_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_load && s1_valid_q) begin
      out_q.pix_x       <= lr_pkg::FIELD_BITS'(s1_x_q);
      out_q.pix_y       <= lr_pkg::FIELD_BITS'(s1_y_q);
      out_q.pixel_index <= index_d;
      out_q.pixel_color <= s1_color_q;
      out_q.last_pixel  <= s1_last_q;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

endmodule

`default_nettype wire

// ===== tb/sv/testbench.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Line rasterizer testbench
// Runs directed lines (a step with no line in progress, a single-point line,
// shallow and steep lines, diagonals, a new line started mid-line, coordinate
// extremes), then random lines under several base address and row width
// settings, zero width included. A line stepper model predicts every pixel
// and its word index. Received pixels are checked in order; both handshakes
// idle in random bursts, with none in the last phase.
// ----------------------------------------------------------------------------

module testbench;

  typedef logic signed [lr_pkg::DEC_BITS-1:0] dec_t;

  logic            clk_i = 1'b0;
  logic            rst_ni = 1'b0;
  logic            cfg_we_i = 1'b0;
  logic            cfg_addr_i = lr_pkg::REG_BASE_ADDRESS;
  logic [31:0]     cfg_wdata_i = '0;
  logic            in_valid_i = 1'b0;
  logic            in_ready_o;
  lr_pkg::lr_in_t  in_data_i = '0;
  logic            out_valid_o;
  logic            out_ready_i = 1'b0;
  lr_pkg::lr_out_t out_data_o;

  line_rasterizer_top u_top (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_addr_i  (cfg_addr_i),
    .cfg_wdata_i (cfg_wdata_i),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .in_data_i   (in_data_i),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_data_o  (out_data_o)
  );

  lr_pkg::lr_in_t  pending_cmds[$];
  lr_pkg::lr_out_t expected_pixels[$];
  int      errors = 0;
  bit      quiet = 1'b0;
  int      in_gap = 0;
  int      out_gap = 0;

  // line stepper state and register copies
  logic [lr_pkg::WORD_BITS-1:0]  fb_base;
  logic [15:0]                   fb_width;
  logic [lr_pkg::COORD_BITS-1:0] pen_x, pen_y, goal_x, goal_y;
  dec_t                          err_acc, inc_straight, inc_diag;
  logic                          major_x, back_x, back_y, drawing;
  logic [lr_pkg::WORD_BITS-1:0]  pen_color;

  initial begin
    forever #4 clk_i = ~clk_i;
  end

  initial begin
    #2ms;
    $display("FAILURE");
    $finish;
  end

  task automatic report(input string what, input logic [31:0] got, input logic [31:0] want);
    if (errors < 40)
      $display("mismatch %s: got %h expected %h", what, got, want);
    errors++;
  endtask

  task automatic trace_pixel(input lr_pkg::lr_in_t t);
    int ax, ay;
    logic fin;
    lr_pkg::lr_out_t px;
    if (t.cmd == lr_pkg::CMD_BEGIN) begin
      ax = t.end_x > t.start_x ? int'(t.end_x) - int'(t.start_x)
                               : int'(t.start_x) - int'(t.end_x);
      ay = t.end_y > t.start_y ? int'(t.end_y) - int'(t.start_y)
                               : int'(t.start_y) - int'(t.end_y);
      pen_x = t.start_x;
      pen_y = t.start_y;
      goal_x = t.end_x;
      goal_y = t.end_y;
      pen_color = t.line_color;
      back_x = !(t.end_x > t.start_x);
      back_y = !(t.end_y > t.start_y);
      major_x = ax > ay;
      if (major_x) begin
        inc_straight = dec_t'(2 * ay);
        inc_diag = dec_t'(2 * (ay - ax));
        err_acc = dec_t'(2 * ay - ax);
        fin = (t.start_x == t.end_x);
      end else begin
        inc_straight = dec_t'(2 * ax);
        inc_diag = dec_t'(2 * (ax - ay));
        err_acc = dec_t'(2 * ax - ay);
        fin = (t.start_y == t.end_y);
      end
      drawing = !fin;
    end else if (!drawing) begin
      return;
    end else begin
      if (err_acc <= 0) begin
        err_acc = err_acc + inc_straight;
        if (major_x)
          pen_x = back_x ? pen_x - 1'b1 : pen_x + 1'b1;
        else
          pen_y = back_y ? pen_y - 1'b1 : pen_y + 1'b1;
      end else begin
        err_acc = err_acc + inc_diag;
        pen_x = back_x ? pen_x - 1'b1 : pen_x + 1'b1;
        pen_y = back_y ? pen_y - 1'b1 : pen_y + 1'b1;
      end
      fin = major_x ? (pen_x == goal_x) : (pen_y == goal_y);
      if (fin)
        drawing = 1'b0;
    end
    px.pix_x = pen_x;
    px.pix_y = pen_y;
    px.pixel_index = fb_base + 32'(fb_width) * 32'(pen_y) + 32'(pen_x);
    px.pixel_color = pen_color;
    px.last_pixel = fin;
    expected_pixels.push_back(px);
  endtask

  // driver
  always @(posedge clk_i) begin
    if (!rst_ni) begin
      in_valid_i <= 1'b0;
    end else begin
      if (in_valid_i && in_ready_o)
        trace_pixel(in_data_i);
      if (!in_valid_i || in_ready_o) begin
        if (in_gap != 0) begin
          in_valid_i <= 1'b0;
          in_gap--;
        end else if (!quiet && $urandom_range(0, 7) == 0) begin
          in_valid_i <= 1'b0;
          in_gap = $urandom_range(0, 9);
        end else if (pending_cmds.size() != 0) begin
          in_data_i <= pending_cmds.pop_front();
          in_valid_i <= 1'b1;
        end else begin
          in_valid_i <= 1'b0;
        end
      end
    end
  end

  // monitor
  always @(posedge clk_i) begin : pixel_monitor
    lr_pkg::lr_out_t want;
    if (!rst_ni) begin
      out_ready_i <= 1'b0;
    end else begin
      if (out_valid_o && out_ready_i) begin
        if (expected_pixels.size() == 0) begin
          report("unexpected pixel index", out_data_o.pixel_index, '0);
        end else begin
          want = expected_pixels.pop_front();
          if (out_data_o.pix_x !== want.pix_x)
            report("pix_x", 32'(out_data_o.pix_x), 32'(want.pix_x));
          if (out_data_o.pix_y !== want.pix_y)
            report("pix_y", 32'(out_data_o.pix_y), 32'(want.pix_y));
          if (out_data_o.pixel_index !== want.pixel_index)
            report("pixel_index", out_data_o.pixel_index, want.pixel_index);
          if (out_data_o.pixel_color !== want.pixel_color)
            report("pixel_color", out_data_o.pixel_color, want.pixel_color);
          if (out_data_o.last_pixel !== want.last_pixel)
            report("last_pixel", 32'(out_data_o.last_pixel), 32'(want.last_pixel));
        end
      end
      if (out_gap != 0) begin
        out_ready_i <= 1'b0;
        out_gap--;
      end else if (!quiet && $urandom_range(0, 7) == 0) begin
        out_ready_i <= 1'b0;
        out_gap = $urandom_range(0, 9);
      end else begin
        out_ready_i <= 1'b1;
      end
    end
  end

  task automatic write_reg(input logic addr, input logic [31:0] data);
    @(posedge clk_i);
    cfg_we_i <= 1'b1;
    cfg_addr_i <= addr;
    cfg_wdata_i <= data;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    if (addr == lr_pkg::REG_BASE_ADDRESS)
      fb_base = data;
    else
      fb_width = data[15:0];
  endtask

  task automatic add_begin(input int sx, input int sy, input int ex, input int ey,
                           input logic [31:0] color);
    lr_pkg::lr_in_t t;
    t.cmd = lr_pkg::CMD_BEGIN;
    t.start_x = sx[15:0];
    t.start_y = sy[15:0];
    t.end_x = ex[15:0];
    t.end_y = ey[15:0];
    t.line_color = color;
    pending_cmds.push_back(t);
  endtask

  task automatic add_steps(input int n);
    lr_pkg::lr_in_t t;
    repeat (n) begin
      t.cmd = lr_pkg::CMD_STEP;
      t.start_x = 16'($urandom);
      t.start_y = 16'($urandom);
      t.end_x = 16'($urandom);
      t.end_y = 16'($urandom);
      t.line_color = $urandom;
      pending_cmds.push_back(t);
    end
  endtask

  task automatic add_random_lines(input int want, input int longest);
    int made, sx, sy, ex, ey, dx, dy, span, len, steps;
    made = 0;
    while (made < want) begin
      sx = $urandom_range(0, 65535);
      sy = $urandom_range(0, 65535);
      if ($urandom_range(0, 24) == 0) begin
        ex = $urandom_range(0, 65535);
        ey = $urandom_range(0, 65535);
      end else begin
        span = ($urandom_range(0, 9) == 0) ? longest : 24;
        dx = $urandom_range(0, span);
        dy = $urandom_range(0, span);
        case ($urandom_range(0, 7))
          0: dy = 0;
          1: dx = 0;
          2: dy = dx;
          default: ;
        endcase
        ex = (sx + dx > 65535 || ($urandom_range(0, 1) == 1 && sx >= dx)) ? sx - dx : sx + dx;
        ey = (sy + dy > 65535 || ($urandom_range(0, 1) == 1 && sy >= dy)) ? sy - dy : sy + dy;
      end
      dx = ex > sx ? ex - sx : sx - ex;
      dy = ey > sy ? ey - sy : sy - ey;
      len = dx > dy ? dx : dy;
      case ($urandom_range(0, 9))
        0: steps = $urandom_range(0, len);
        1: steps = len + $urandom_range(1, 3);
        default: steps = len;
      endcase
      if (steps > longest + 3)
        steps = $urandom_range(0, 60);
      add_begin(sx, sy, ex, ey, $urandom);
      add_steps(steps);
      made += 1 + (steps < len ? steps : len);
    end
  endtask

  task automatic drain();
    while (pending_cmds.size() != 0 || in_valid_i || expected_pixels.size() != 0)
      @(negedge clk_i);
    repeat (6) @(negedge clk_i);
  endtask

  task automatic run_phase(input logic [31:0] base, input logic [15:0] width,
                           input int want, input int longest);
    write_reg(lr_pkg::REG_BASE_ADDRESS, base);
    write_reg(lr_pkg::REG_LINE_WIDTH, {16'h0, width});
    add_random_lines(want, longest);
    drain();
  endtask

  initial begin
    fb_base = '0;
    fb_width = lr_pkg::LINE_WIDTH_RESET;
    {pen_x, pen_y, goal_x, goal_y} = '0;
    {err_acc, inc_straight, inc_diag} = '0;
    {major_x, back_x, back_y, drawing} = '0;
    pen_color = '0;
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;

    add_steps(1);
    add_begin(5, 5, 5, 5, 32'h0000_0000);
    add_steps(1);
    add_begin(0, 0, 6, 2, 32'hFFFF_FFFF);
    add_steps(6);
    add_begin(16'hFFFF, 16'hFFFF, 16'hFFFD, 16'hFFF7, 32'hA5A5_5A5A);
    add_steps(3);
    add_begin(10, 10, 7, 13, 32'h5A5A_A5A5);
    add_steps(3);
    add_begin(2, 4, 5, 4, 32'h1234_5678);
    add_steps(3);
    add_begin(0, 16'hFFFF, 16'hFFFF, 0, 32'hFFFF_0000);
    add_steps(1);
    drain();

    run_phase(32'hFFFF_FFFF, 16'hFFFF, 80, 150);
    run_phase(32'h0000_0000, 16'h0000, 55, 60);
    run_phase($urandom, 16'h0001, 55, 60);
    run_phase($urandom, 16'($urandom_range(1, 65535)), 100, 150);
    quiet = 1'b1;
    run_phase($urandom, lr_pkg::LINE_WIDTH_RESET, 80, 60);

    if (errors == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule
